/* hdl/rm_pkg.sv */
// ----------------------------------------------------------------------------
// rm_pkg
// Shared sizes, types and the cell control bundle for the running median.
// ----------------------------------------------------------------------------
package rm_pkg;

    localparam int CAPACITY    = 256;
    localparam int SAMPLE_W    = 32;
    localparam int OUT_COUNT_W = 9;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int GROUP_SIZE  = 16;
    localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic [SAMPLE_W-1:0]    sample_t;
    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [OUT_COUNT_W-1:0] out_count_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic   ins;
        count_t count;
        idx_t   lo_idx;
        idx_t   hi_idx;
    } cell_ctrl_t;

endpackage

/* hdl/rm_cell.sv */
// ----------------------------------------------------------------------------
// rm_cell
// One slot of the sorted chain: holds a sample, shifts up on insert and
// taps its value out when it sits at a median rank.
// ----------------------------------------------------------------------------
module rm_cell
    import rm_pkg::*;
(
    input  logic       clk,
    input  idx_t       idx,
    input  cell_ctrl_t ctrl,
    input  sample_t    sample,
    input  sample_t    left_value,
    input  logic       left_gt,
    output sample_t    value,
    output logic       gt,
    output sample_t    lo_tap,
    output sample_t    hi_tap
);

    sample_t value_reg;
    sample_t value_next;
    logic    occupied;
    logic    is_end;

    assign occupied = count_t'(idx) < ctrl.count;
    assign is_end   = count_t'(idx) == ctrl.count;
    assign gt       = occupied && (value_reg > sample);
    assign value    = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins)
        begin
            if (left_gt)
            begin
                value_next = left_value;
            end
            else if (gt || is_end)
            begin
                value_next = sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign lo_tap = (idx == ctrl.lo_idx) ? value_reg : '0;
    assign hi_tap = (idx == ctrl.hi_idx) ? value_reg : '0;

endmodule

/* hdl/rm_median.sv */
// ----------------------------------------------------------------------------
// rm_median
// Two-level registered OR tree that collects the two median taps.
// ----------------------------------------------------------------------------
module rm_median
    import rm_pkg::*;
(
    input  logic    clk,
    input  sample_t lo_taps [CAPACITY],
    input  sample_t hi_taps [CAPACITY],
    output sample_t lo_value,
    output sample_t hi_value
);

    sample_t lo_group_reg [NUM_GROUPS];
    sample_t hi_group_reg [NUM_GROUPS];
    sample_t lo_group_next [NUM_GROUPS];
    sample_t hi_group_next [NUM_GROUPS];
    sample_t lo_value_reg;
    sample_t hi_value_reg;
    sample_t lo_value_next;
    sample_t hi_value_next;

    // at most one tap is nonzero per side, so an or acts as a select
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            lo_group_next[g] = '0;
            hi_group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < CAPACITY)
                begin
                    lo_group_next[g] = lo_group_next[g] | lo_taps[g * GROUP_SIZE + k];
                    hi_group_next[g] = hi_group_next[g] | hi_taps[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb
    begin
        lo_value_next = '0;
        hi_value_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            lo_value_next = lo_value_next | lo_group_reg[g];
            hi_value_next = hi_value_next | hi_group_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        lo_group_reg <= lo_group_next;
        hi_group_reg <= hi_group_next;
        lo_value_reg <= lo_value_next;
        hi_value_reg <= hi_value_next;
    end

    assign lo_value = lo_value_reg;
    assign hi_value = hi_value_reg;

endmodule

/* hdl/running_median.sv */
// ----------------------------------------------------------------------------
// running_median
// Running median over a sorted chain of sample cells.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   in      | input     | in_valid / in_ready | sample
//   out     | output    | out_valid/out_ready | median_value, sample_count, overflow
//
// an item goes through insert into the chain, group-level tap select,
// final tap select, then the 33-bit average into the output register
// a new beat is taken once the previous one has reached the output register,
// even while that result still waits for out_ready
// a stalled output holds the last stage until the register frees up
// reset empties the chain through the count alone; cell contents are not cleared
// ----------------------------------------------------------------------------
module running_median
    import rm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sample_t    sample,
    output logic       out_valid,
    input  logic       out_ready,
    output sample_t    median_value,
    output out_count_t sample_count,
    output logic       overflow
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_MERGE,
        ST_SEND
    } state_t;

    state_t     state_reg;
    count_t     count_reg;
    logic       dropped_reg;
    logic       out_valid_reg;
    sample_t    median_reg;
    out_count_t out_count_reg;
    logic       overflow_reg;

    logic       accept;
    logic       full;
    logic       out_free;
    cell_ctrl_t ctrl;
    count_t     lo_rank;
    count_t     hi_rank;
    sample_t    cell_value [CAPACITY];
    logic       cell_gt    [CAPACITY];
    sample_t    lo_taps    [CAPACITY];
    sample_t    hi_taps    [CAPACITY];
    sample_t    lo_value;
    sample_t    hi_value;
    logic [SAMPLE_W:0] pair_sum;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == count_t'(CAPACITY));
    assign out_free = !out_valid_reg || out_ready;

    assign lo_rank = (count_reg - count_t'(1)) >> 1;
    assign hi_rank = count_reg >> 1;

    assign ctrl.ins    = accept && !full;
    assign ctrl.count  = count_reg;
    assign ctrl.lo_idx = lo_rank[IDX_W-1:0];
    assign ctrl.hi_idx = hi_rank[IDX_W-1:0];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            rm_cell u_cell (
                .clk        (clk),
                .idx        (idx_t'(i)),
                .ctrl       (ctrl),
                .sample     (sample),
                .left_value ('0),
                .left_gt    (1'b0),
                .value      (cell_value[i]),
                .gt         (cell_gt[i]),
                .lo_tap     (lo_taps[i]),
                .hi_tap     (hi_taps[i])
            );
        end
        else
        begin : g_body
            rm_cell u_cell (
                .clk        (clk),
                .idx        (idx_t'(i)),
                .ctrl       (ctrl),
                .sample     (sample),
                .left_value (cell_value[i-1]),
                .left_gt    (cell_gt[i-1]),
                .value      (cell_value[i]),
                .gt         (cell_gt[i]),
                .lo_tap     (lo_taps[i]),
                .hi_tap     (hi_taps[i])
            );
        end
    end

    rm_median u_median (
        .clk      (clk),
        .lo_taps  (lo_taps),
        .hi_taps  (hi_taps),
        .lo_value (lo_value),
        .hi_value (hi_value)
    );

    // odd count: both ranks point at the same cell, so the average is exact
    assign pair_sum = {1'b0, lo_value} + {1'b0, hi_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            median_reg    <= '0;
            out_count_reg <= '0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_SEND && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        dropped_reg <= full;
                        if (!full)
                        begin
                            count_reg <= count_reg + count_t'(1);
                        end
                        state_reg <= ST_GROUP;
                    end
                end
                ST_GROUP:
                begin
                    state_reg <= ST_MERGE;
                end
                ST_MERGE:
                begin
                    state_reg <= ST_SEND;
                end
                ST_SEND:
                begin
                    if (out_free)
                    begin
                        median_reg    <= pair_sum[SAMPLE_W:1];
                        out_count_reg <= out_count_t'(count_reg);
                        overflow_reg  <= dropped_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign median_value = median_reg;
    assign sample_count = out_count_reg;
    assign overflow     = overflow_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("held count above capacity");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second beat taken while an item is in flight");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && overflow_reg) |-> full)
        else $error("overflow reported with room left");

    a_result_from_send: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_SEND)
        else $error("result loaded outside the send step");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full) |=> count_reg == $past(count_reg) + count_t'(1))
        else $error("count did not advance on insert");

endmodule

/* tb/tb_running_median.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_median
// Streams samples into the running median block and checks every result
// beat against a sorted-store model held in the bench. A short table of
// edge values runs first, then random samples under changing idle and stall
// patterns, including one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_running_median;
    import rm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 730;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int NUM_STEPS    = 20;

    typedef struct packed {
        sample_t    median;
        out_count_t count;
        logic       overflow;
    } median_result_t;

    // typed_out set means the row carries its own result
    typedef struct packed {
        sample_t        sample;
        logic           typed_out;
        median_result_t result;
    } median_step_t;

    localparam median_step_t DIRECTED_STEPS [NUM_STEPS] = '{
        '{32'h0000_0000, 1'b1, '{32'h0000_0000, 9'd1, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, '{32'h7FFF_FFFF, 9'd2, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 9'd3, 1'b0}},
        // middle pair both at max, sum needs the 33rd bit
        '{32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 9'd4, 1'b0}},
        '{32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 9'd5, 1'b0}},
        '{32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, 9'd6, 1'b0}},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h8000_0000, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, '0},
        '{32'h0000_0001, 1'b0, '0},
        '{32'hFFFF_FFFE, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'h1234_5678, 1'b0, '0},
        '{32'h0000_0005, 1'b0, '0},
        '{32'h0000_0005, 1'b0, '0},
        '{32'h0000_0005, 1'b0, '0},
        '{32'h0000_0005, 1'b0, '0},
        '{32'h8000_0001, 1'b0, '0},
        '{32'hC3A5_5A3C, 1'b0, '0}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    sample_t    sample = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    sample_t    median_value;
    out_count_t sample_count;
    logic       overflow;

    median_result_t pending_medians[$];
    sample_t        sorted_samples [CAPACITY];
    int             held_samples = 0;
    sample_t        last_sample = '0;
    int             mismatch_count = 0;
    int unsigned    cycle_count = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;
    logic           hold_trigger = 1'b0;
    logic           hold_taken = 1'b0;
    int             hold_left = 0;

    running_median uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .median_value (median_value),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    always #5 clk = ~clk;

    // insert into the bench copy of the store and read back the median
    function automatic median_result_t predict_median(input sample_t s);
        median_result_t res;
        int             pos;
        logic [32:0]    pair_sum;
        res.overflow = (held_samples >= CAPACITY);
        if (!res.overflow)
        begin
            pos = held_samples;
            while (pos > 0 && sorted_samples[pos-1] > s)
            begin
                sorted_samples[pos] = sorted_samples[pos-1];
                pos--;
            end
            sorted_samples[pos] = s;
            held_samples++;
        end
        if (held_samples % 2 == 1)
            res.median = sorted_samples[(held_samples - 1) / 2];
        else
        begin
            pair_sum = {1'b0, sorted_samples[held_samples/2 - 1]}
                     + {1'b0, sorted_samples[held_samples/2]};
            res.median = pair_sum[32:1];
        end
        res.count = out_count_t'(held_samples);
        return res;
    endfunction

    function automatic sample_t pick_sample();
        sample_t s;
        case ($urandom_range(9))
            3: s = $urandom_range(1) ? '1 : '0;
            4: s = sample_t'($urandom_range(15));
            5: s = '1 - sample_t'($urandom_range(15));
            6: s = sample_t'(1) << $urandom_range(SAMPLE_W - 1);
            7: s = last_sample;
            8: s = last_sample + sample_t'($urandom_range(3));
            default: s = $urandom;
        endcase
        return s;
    endfunction

    task automatic send_sample(input median_step_t step);
        median_result_t res;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= step.sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = predict_median(step.sample);
        pending_medians = {pending_medians, (step.typed_out ? step.result : res)};
        last_sample = step.sample;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        idle_pct = sender_pct;
        stall_pct <= receiver_pct;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold counted here
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_trigger && !hold_taken)
        begin
            out_ready  <= 1'b0;
            hold_left  <= LONG_HOLD;
            hold_taken <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        median_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_medians.size() == 0)
            begin
                $display("%0t: unexpected beat: median %h count %0d overflow %b",
                         $time, median_value, sample_count, overflow);
                mismatch_count++;
            end
            else
            begin
                want = pending_medians.pop_front();
                if (median_value !== want.median)
                begin
                    $display("%0t: median_value expected %h actual %h",
                             $time, want.median, median_value);
                    mismatch_count++;
                end
                if (sample_count !== want.count)
                begin
                    $display("%0t: sample_count expected %0d actual %0d",
                             $time, want.count, sample_count);
                    mismatch_count++;
                end
                if (overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.overflow, overflow);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        median_step_t step;
        int           mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        for (int i = 0; i < NUM_STEPS; i++)
            send_sample(DIRECTED_STEPS[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            mode = (i / 64) % 4;
            case (mode)
                0: set_idling(0, 0);
                1: set_idling(52, 0);
                2: set_idling(0, 52);
                default: set_idling(31, 31);
            endcase
            // long output hold while the input keeps offering beats
            if (i == 40)
                hold_trigger <= 1'b1;
            step.sample    = pick_sample();
            step.typed_out = 1'b0;
            step.result    = '0;
            send_sample(step);
        end
        in_valid <= 1'b0;
        set_idling(0, 0);

        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rm_pkg.sv
hdl/rm_cell.sv
hdl/rm_median.sv
hdl/running_median.sv
tb/tb_running_median.sv
